>>> hw/rtl/lcd_pkg.sv
// ----------------------------------------------------------------------------
// Lock-order cycle detector package
// Shared item codes and controller state type.
// ----------------------------------------------------------------------------
package lcd_pkg;

    localparam int unsigned IdW = 5;

    typedef enum logic [0:0] {
        ACT_ACQUIRE = 1'b0,
        ACT_RELEASE = 1'b1
    } t_action;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_WRONG    = 3'd2,
        ST_DEADLOCK = 3'd3,
        ST_OVERFLOW = 3'd4,
        ST_HALTED   = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TOP,
        S_EROW,
        S_PICK,
        S_SCAN
    } t_state;

endpackage

>>> hw/rtl/lcd_if.sv
// ----------------------------------------------------------------------------
// Lock-order cycle detector channels
// Valid/ready channels for incoming lock actions and outgoing results.
// ----------------------------------------------------------------------------
interface lcd_in_if import lcd_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 action;
    logic [IdW-1:0]       lock_id;
    modport source (output valid, output action, output lock_id, input ready);
    modport sink   (input valid, input action, input lock_id, output ready);
endinterface

interface lcd_out_if import lcd_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic        new_edge;
    modport source (output valid, output status, output new_edge, input ready);
    modport sink   (input valid, input status, input new_edge, output ready);
endinterface

>>> hw/rtl/lcd_edge_mem.sv
// ----------------------------------------------------------------------------
// Lock-order edge matrix
// One row per lock, synchronous read; rows never written read as zero.
// ----------------------------------------------------------------------------
module lcd_edge_mem #(
    parameter int unsigned NUM_LOCKS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_we,
    input  logic [$clog2(NUM_LOCKS)-1:0] i_waddr,
    input  logic [NUM_LOCKS-1:0]         i_wdata,
    input  logic [$clog2(NUM_LOCKS)-1:0] i_raddr,
    output logic [NUM_LOCKS-1:0]         o_rdata
);
    logic [NUM_LOCKS-1:0] r_mem [NUM_LOCKS];
    logic [NUM_LOCKS-1:0] r_row_valid;
    logic [NUM_LOCKS-1:0] r_rdata;
    logic                 r_rvalid;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
            r_rvalid    <= 1'b0;
        end else begin
            r_rvalid <= r_row_valid[i_raddr];
            if (i_we) begin
                r_row_valid[i_waddr] <= 1'b1;
            end
        end
    end

    assign o_rdata = r_rvalid ? r_rdata : '0;
endmodule

>>> hw/rtl/lcd_held_stack.sv
// ----------------------------------------------------------------------------
// Held-lock stack memory
// Stack of held lock numbers, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module lcd_held_stack #(
    parameter int unsigned NUM_LOCKS   = 32,
    parameter int unsigned STACK_DEPTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_we,
    input  logic [$clog2(STACK_DEPTH)-1:0] i_waddr,
    input  logic [$clog2(NUM_LOCKS)-1:0]   i_wdata,
    input  logic [$clog2(STACK_DEPTH)-1:0] i_raddr,
    output logic [$clog2(NUM_LOCKS)-1:0]   o_rdata
);
    logic [$clog2(NUM_LOCKS)-1:0] r_mem [STACK_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> hw/rtl/lock_order_cycle_detector_unit.sv
// ----------------------------------------------------------------------------
// Lock-order cycle detector
// Tracks held locks and lock-order edges and reports deadlock cycles.
// ----------------------------------------------------------------------------
// Each item acquires or releases one lock and yields exactly one result item.
// An acquire that adds a new edge top->id runs a reachability search from
// id over the edge matrix, one lock expanded at a time (a pick step and a
// scan step) through the single read port of the edge memory. Because the
// graph had no cycle before, the new edge closes a cycle exactly when top
// can be reached from id. Any error halts the block until reset; while
// halted every item answers with the halted status.
module lock_order_cycle_detector_unit import lcd_pkg::*; #(
    parameter int unsigned NUM_LOCKS   = 32,
    parameter int unsigned STACK_DEPTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lcd_in_if.sink    i_in,
    lcd_out_if.source o_out
);
    localparam int unsigned LW = $clog2(NUM_LOCKS);
    localparam int unsigned SW = $clog2(STACK_DEPTH);
    localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

    // Lock numbers are reduced modulo NUM_LOCKS through an elaborated table.
    logic [LW-1:0] w_mod [2**IdW];
    for (genvar v = 0; v < 2**IdW; v++) begin : g_mod
        assign w_mod[v] = LW'(v % NUM_LOCKS);
    end

    t_state              r_state, n_state;
    logic                r_act, n_act;
    logic [LW-1:0]       r_id, n_id;
    logic [LW-1:0]       r_top, n_top;
    logic [CW-1:0]       r_count, n_count;
    logic                r_halt, n_halt;
    logic [NUM_LOCKS-1:0] r_reached, n_reached;
    logic [NUM_LOCKS-1:0] r_pending, n_pending;
    logic                r_ov, n_ov;
    t_status             r_ostat, n_ostat;
    logic                r_oedge, n_oedge;

    logic                stk_we;
    logic [SW-1:0]       stk_waddr, stk_raddr;
    logic [LW-1:0]       stk_rdata;
    logic                em_we;
    logic [LW-1:0]       em_waddr, em_raddr;
    logic [NUM_LOCKS-1:0] em_wdata, em_rdata;
    logic [NUM_LOCKS-1:0] w_id_bit;
    logic [LW-1:0]       w_pick;

    lcd_held_stack #(.NUM_LOCKS(NUM_LOCKS), .STACK_DEPTH(STACK_DEPTH)) u_stack (
        .i_clk  (i_clk),
        .i_we   (stk_we),
        .i_waddr(stk_waddr),
        .i_wdata(r_id),
        .i_raddr(stk_raddr),
        .o_rdata(stk_rdata)
    );

    lcd_edge_mem #(.NUM_LOCKS(NUM_LOCKS)) u_edges (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_we   (em_we),
        .i_waddr(em_waddr),
        .i_wdata(em_wdata),
        .i_raddr(em_raddr),
        .o_rdata(em_rdata)
    );

    assign w_id_bit  = {{(NUM_LOCKS-1){1'b0}}, 1'b1} << r_id;
    assign stk_waddr = r_count[SW-1:0];

    // Lowest pending lock is expanded next.
    always_comb begin
        w_pick = '0;
        for (int i = NUM_LOCKS - 1; i >= 0; i--) begin
            if (r_pending[i]) begin
                w_pick = LW'(i);
            end
        end
    end

    assign i_in.ready     = (r_state == S_IDLE) && !r_ov;
    assign o_out.valid    = r_ov;
    assign o_out.status   = r_ostat;
    assign o_out.new_edge = r_oedge;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_halt  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_halt  <= n_halt;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act     <= n_act;
        r_id      <= n_id;
        r_top     <= n_top;
        r_reached <= n_reached;
        r_pending <= n_pending;
        r_ostat   <= n_ostat;
        r_oedge   <= n_oedge;
    end

    always_comb begin
        n_state   = r_state;
        n_act     = r_act;
        n_id      = r_id;
        n_top     = r_top;
        n_count   = r_count;
        n_halt    = r_halt;
        n_reached = r_reached;
        n_pending = r_pending;
        n_ov      = r_ov && !o_out.ready;
        n_ostat   = r_ostat;
        n_oedge   = r_oedge;
        stk_we    = 1'b0;
        stk_raddr = SW'(r_count - CW'(1));
        em_we     = 1'b0;
        em_waddr  = r_top;
        em_wdata  = em_rdata | w_id_bit;
        em_raddr  = r_top;

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid && i_in.ready) begin
                    n_act   = i_in.action;
                    n_id    = w_mod[i_in.lock_id];
                    n_state = S_TOP;
                end
            end
            S_TOP: begin
                n_top   = stk_rdata;
                n_state = S_IDLE;
                n_ov    = 1'b1;
                n_oedge = 1'b0;
                n_ostat = ST_OK;
                if (r_halt) begin
                    n_ostat = ST_HALTED;
                end else if (r_act == ACT_RELEASE) begin
                    if (r_count == '0) begin
                        n_ostat = ST_EMPTY;
                        n_halt  = 1'b1;
                    end else if (stk_rdata != r_id) begin
                        n_ostat = ST_WRONG;
                        n_halt  = 1'b1;
                    end else begin
                        n_count = r_count - CW'(1);
                    end
                end else if (r_count >= CW'(STACK_DEPTH)) begin
                    n_ostat = ST_OVERFLOW;
                    n_halt  = 1'b1;
                end else if (r_count == '0 || stk_rdata == r_id) begin
                    stk_we  = 1'b1;
                    n_count = r_count + CW'(1);
                end else begin
                    // Fetch the top lock's row to see if the edge is known.
                    n_ov     = r_ov && !o_out.ready;
                    em_raddr = stk_rdata;
                    n_state  = S_EROW;
                end
            end
            S_EROW: begin
                if (em_rdata[r_id]) begin
                    stk_we  = 1'b1;
                    n_count = r_count + CW'(1);
                    n_ov    = 1'b1;
                    n_ostat = ST_OK;
                    n_oedge = 1'b0;
                    n_state = S_IDLE;
                end else begin
                    em_we     = 1'b1;
                    n_reached = w_id_bit;
                    n_pending = w_id_bit;
                    n_state   = S_PICK;
                end
            end
            S_PICK: begin
                if (r_pending == '0) begin
                    // Top is not reachable from the new lock: no cycle.
                    stk_we  = 1'b1;
                    n_count = r_count + CW'(1);
                    n_ov    = 1'b1;
                    n_ostat = ST_OK;
                    n_oedge = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    em_raddr  = w_pick;
                    n_pending = r_pending & ~({{(NUM_LOCKS-1){1'b0}}, 1'b1} << w_pick);
                    n_state   = S_SCAN;
                end
            end
            S_SCAN: begin
                if (em_rdata[r_top]) begin
                    n_ov    = 1'b1;
                    n_ostat = ST_DEADLOCK;
                    n_oedge = 1'b1;
                    n_halt  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_pending = r_pending | (em_rdata & ~r_reached);
                    n_reached = r_reached | em_rdata;
                    n_state   = S_PICK;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> r_halt) else $error("halt flag cleared without reset");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(STACK_DEPTH)) else $error("held count beyond stack depth");

    a_halted_no_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> $stable(r_count)) else $error("stack changed while halted");

    a_deadlock_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_ostat != ST_OK) |-> r_halt) else $error("error result without halt");
endmodule
